[sv/scfc_pkg.sv]
`timescale 1ns / 1ps

package scfc_pkg;

  // Fixed-point constants (positions Q2.14, samples at 1/2048 V)
  localparam int unsigned SMP_W       = 16;
  localparam int unsigned CLIP_W      = 15;
  localparam int unsigned OP_W        = 25;
  localparam int unsigned PROD_W      = 2 * OP_W;
  localparam int unsigned ACC_W       = 36;
  localparam int unsigned CVSUM_W     = 23;
  localparam int unsigned CV_SHIFT    = 11;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned CURVE_SHIFT = 14;
  localparam int unsigned MIX_SHIFT   = 15;
  localparam int          ONE_Q14     = 16384;
  localparam int          CV_RND      = 5120;
  localparam int          CURVE_RND   = 8192;
  localparam int          MIX_RND     = 16384;
  // ceil(2^26 / 5); exact floor-divide by 5 for operands below 2^23
  localparam int          RECIP5      = 13421773;
  // Offset (a multiple of 5) that keeps the divide-by-5 operand positive
  localparam int          Q_BIAS      = 2 ** 20;
  localparam int          CV_BIAS     = 5 * Q_BIAS;

  localparam logic signed [SMP_W-1:0] POS_ONE = 16'sd16384;
  localparam logic signed [SMP_W-1:0] NEG_ONE = -16'sd16384;

  // Configuration register indexes
  localparam logic [2:0] REG_KNOB     = 3'd0;
  localparam logic [2:0] REG_TRIM     = 3'd1;
  localparam logic [2:0] REG_FADE     = 3'd2;
  localparam logic [2:0] REG_CV_CONN  = 3'd3;
  localparam logic [2:0] REG_TRIG     = 3'd4;
  localparam logic [2:0] REG_TRIG_LO  = 3'd5;
  localparam logic [2:0] REG_TRIG_HI  = 3'd6;
  localparam logic [2:0] REG_CLIP     = 3'd7;

  // Fade curve codes (any other code is linear)
  localparam logic [1:0] FADE_LOG    = 2'd0;
  localparam logic [1:0] FADE_LINEAR = 2'd1;
  localparam logic [1:0] FADE_EXP    = 2'd2;

  typedef enum logic [1:0] {
    OVR_NONE = 2'd0,
    OVR_NEG  = 2'd1,
    OVR_POS  = 2'd2
  } ovr_t;

  // Microcode fields
  typedef logic [3:0] step_t;
  localparam step_t LAST_STEP = 4'd11;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_CV_TRIM, MUL_RECIP, MUL_CURVE,
    MUL_WA_A1, MUL_WB_B1, MUL_WA_A2, MUL_WB_B2
  } mul_sel_t;

  typedef enum logic [1:0] { ACC_HOLD, ACC_LOAD, ACC_ADD } acc_op_t;
  typedef enum logic [1:0] { RND_ZERO, RND_CV, RND_MIX } rnd_sel_t;
  typedef enum logic [1:0] { POS_HOLD, POS_CV, POS_CURVE } pos_op_t;
  typedef enum logic [1:0] { JC_NEVER, JC_NOT_CVADD, JC_LINEAR } jump_cond_t;

  typedef struct packed {
    mul_sel_t   mul;
    acc_op_t    acc;
    rnd_sel_t   rnd;
    pos_op_t    pos;
    logic       left_wr;
    logic       done;
    jump_cond_t cond;
    step_t      target;
  } uop_t;

  // Branch status from the datapath configuration
  typedef struct packed {
    logic cv_add;
    logic linear;
  } seq_stat_t;

  localparam uop_t UOP_NOP = '{mul: MUL_NONE, acc: ACC_HOLD, rnd: RND_ZERO,
                               pos: POS_HOLD, left_wr: 1'b0, done: 1'b0,
                               cond: JC_NEVER, target: '0};

  // Control store: CV offset, curve shaping, then the two mixes
  function automatic uop_t uop_rom(input step_t s);
    uop_t u;
    u = UOP_NOP;
    unique case (s)
      4'd0: begin
        u.mul    = MUL_CV_TRIM;
        u.cond   = JC_NOT_CVADD;
        u.target = 4'd4;
      end
      4'd1: begin
        u.acc = ACC_LOAD;
        u.rnd = RND_CV;
      end
      4'd2: u.mul = MUL_RECIP;
      4'd3: u.pos = POS_CV;
      4'd4: begin
        u.mul    = MUL_CURVE;
        u.cond   = JC_LINEAR;
        u.target = 4'd6;
      end
      4'd5: u.pos = POS_CURVE;
      4'd6: u.mul = MUL_WA_A1;
      4'd7: begin
        u.mul = MUL_WB_B1;
        u.acc = ACC_LOAD;
        u.rnd = RND_MIX;
      end
      4'd8: begin
        u.mul = MUL_WA_A2;
        u.acc = ACC_ADD;
      end
      4'd9: begin
        u.mul     = MUL_WB_B2;
        u.acc     = ACC_LOAD;
        u.rnd     = RND_MIX;
        u.left_wr = 1'b1;
      end
      4'd10: u.acc = ACC_ADD;
      4'd11: u.done = 1'b1;
      default: u.done = 1'b1;
    endcase
    return u;
  endfunction

endpackage

[sv/scfc_in_if.sv]
`timescale 1ns / 1ps

interface scfc_in_if import scfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] control_voltage;
  logic                    toggle_button;
  logic signed [SMP_W-1:0] sample_a1;
  logic signed [SMP_W-1:0] sample_b1;
  logic signed [SMP_W-1:0] sample_a2;
  logic signed [SMP_W-1:0] sample_b2;
  logic                    a2_present;
  logic                    b2_present;

  modport source (output valid, control_voltage, toggle_button, sample_a1, sample_b1,
                  sample_a2, sample_b2, a2_present, b2_present, input ready);
  modport sink   (input valid, control_voltage, toggle_button, sample_a1, sample_b1,
                  sample_a2, sample_b2, a2_present, b2_present, output ready);
endinterface

[sv/scfc_out_if.sv]
`timescale 1ns / 1ps

interface scfc_out_if import scfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_out;
  logic signed [SMP_W-1:0] right_out;
  logic signed [SMP_W-1:0] current_position;

  modport source (output valid, left_out, right_out, current_position, input ready);
  modport sink   (input valid, left_out, right_out, current_position, output ready);
endinterface

[sv/scfc_cfg_if.sv]
`timescale 1ns / 1ps

interface scfc_cfg_if import scfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       index;
  logic [SMP_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/stereo_crossfader_with_curve_top.sv]
`timescale 1ns / 1ps
// Each frame runs as a microcode program on a single shared multiplier; the CV
//   offset steps are skipped when CV is unpatched or in trigger mode, and the curve
//   write-back with a linear curve. A new frame is accepted only after the last
//   one finishes; a held result stalls the last step.
// Reset (rst_n low, synchronous): registers at defaults, no override, trigger low.
module stereo_crossfader_with_curve_top import scfc_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  scfc_in_if.sink     in_ch,
  scfc_out_if.source  out_ch,
  scfc_cfg_if.sink    cfg_ch
);

  logic signed [SMP_W-1:0]  knob_r, trim_r, trig_lo_r, trig_hi_r;
  logic [1:0]               fade_r;
  logic                     cv_conn_r, trig_mode_r;
  logic [CLIP_W-1:0]        clip_r;
  ovr_t                     ovr_r, ovr_nxt;
  logic                     sch_r, sch_nxt;
  logic                     fire;
  logic signed [SMP_W-1:0]  man_cur, man_new;
  logic signed [SMP_W-1:0]  a2_eff, b2_eff;
  logic                     in_acc, cfg_acc, out_free, finish, busy;
  uop_t                     uop;
  seq_stat_t                stat;
  logic                     out_valid_r;
  logic signed [SMP_W-1:0]  left_r, right_r, cur_r;
  logic signed [SMP_W-1:0]  left_res, right_res, cur_pos;

  function automatic logic signed [SMP_W-1:0] manual_pos(input ovr_t o,
                                                         input logic signed [SMP_W-1:0] k);
    logic signed [SMP_W-1:0] r;
    case (o)
      OVR_NEG: r = NEG_ONE;
      OVR_POS: r = POS_ONE;
      default: r = (k > POS_ONE) ? POS_ONE : ((k < NEG_ONE) ? NEG_ONE : k);
    endcase
    return r;
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = !busy;
  assign cfg_ch.ready = 1'b1;

  // Schmitt trigger on the button or the CV, and toggle override
  always_comb begin
    man_cur = manual_pos(ovr_r, knob_r);
    sch_nxt = sch_r;
    fire    = 1'b0;
    if (in_acc && !cv_conn_r) begin
      if (sch_r) begin
        if (!in_ch.toggle_button) sch_nxt = 1'b0;
      end else if (in_ch.toggle_button) begin
        sch_nxt = 1'b1;
        fire    = 1'b1;
      end
    end else if (in_acc && trig_mode_r) begin
      if (sch_r) begin
        if (in_ch.control_voltage <= trig_lo_r) sch_nxt = 1'b0;
      end else if (in_ch.control_voltage >= trig_hi_r) begin
        sch_nxt = 1'b1;
        fire    = 1'b1;
      end
    end
    ovr_nxt = ovr_r;
    if (fire) ovr_nxt = (man_cur >= 0) ? OVR_NEG : OVR_POS;
    // a knob write drops any override
    if (cfg_acc && cfg_ch.index == REG_KNOB) ovr_nxt = OVR_NONE;
    man_new = manual_pos(ovr_nxt, knob_r);
  end

  assign a2_eff = in_ch.a2_present ? in_ch.sample_a2 : in_ch.sample_b1;
  assign b2_eff = in_ch.b2_present ? in_ch.sample_b2 : in_ch.sample_a1;

  // Configuration registers and toggle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_r      <= '0;
      trim_r      <= '0;
      fade_r      <= FADE_LINEAR;
      cv_conn_r   <= 1'b0;
      trig_mode_r <= 1'b0;
      trig_lo_r   <= 16'sd205;
      trig_hi_r   <= 16'sd2048;
      clip_r      <= 15'd24576;
      ovr_r       <= OVR_NONE;
      sch_r       <= 1'b0;
    end else begin
      ovr_r <= ovr_nxt;
      sch_r <= sch_nxt;
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_KNOB:    knob_r      <= signed'(cfg_ch.data);
          REG_TRIM:    trim_r      <= signed'(cfg_ch.data);
          REG_FADE:    fade_r      <= cfg_ch.data[1:0];
          REG_CV_CONN: cv_conn_r   <= cfg_ch.data[0];
          REG_TRIG:    trig_mode_r <= cfg_ch.data[0];
          REG_TRIG_LO: trig_lo_r   <= signed'(cfg_ch.data);
          REG_TRIG_HI: trig_hi_r   <= signed'(cfg_ch.data);
          REG_CLIP:    clip_r      <= cfg_ch.data[CLIP_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  assign stat.cv_add = cv_conn_r && !trig_mode_r;
  assign stat.linear = (fade_r != FADE_LOG) && (fade_r != FADE_EXP);

  scfc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .stat     (stat),
    .uop      (uop),
    .finish   (finish),
    .busy     (busy)
  );

  scfc_dp u_dp (
    .clk        (clk),
    .start      (in_acc),
    .uop        (uop),
    .cv         (in_ch.control_voltage),
    .a1         (in_ch.sample_a1),
    .b1         (in_ch.sample_b1),
    .a2         (a2_eff),
    .b2         (b2_eff),
    .man_pos    (man_new),
    .cv_trim    (trim_r),
    .fade_mode  (fade_r),
    .clip_limit (clip_r),
    .left_res   (left_res),
    .right_res  (right_res),
    .cur_pos    (cur_pos)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      left_r  <= left_res;
      right_r <= right_res;
      cur_r   <= cur_pos;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.left_out         = left_r;
  assign out_ch.right_out        = right_r;
  assign out_ch.current_position = cur_r;

endmodule

[sv/scfc_seq.sv]
`timescale 1ns / 1ps

module scfc_seq import scfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      out_free,
  input  seq_stat_t stat,
  output uop_t      uop,
  output logic      finish,
  output logic      busy
);

  logic  busy_r, busy_nxt;
  step_t step_r, step_nxt;
  uop_t  uop_raw;
  logic  take;

  // Fetch and branch decision
  always_comb begin
    uop_raw = uop_rom(step_r);
    unique case (uop_raw.cond)
      JC_NOT_CVADD: take = !stat.cv_add;
      JC_LINEAR:    take = stat.linear;
      default:      take = 1'b0;
    endcase
  end

  // Step counter: the final word waits until the result register is free
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (uop_raw.done) begin
        if (out_free) busy_nxt = 1'b0;
      end else if (take) begin
        step_nxt = uop_raw.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign uop    = busy_r ? uop_raw : UOP_NOP;
  assign finish = busy_r && uop_raw.done && out_free;
  assign busy   = busy_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("transaction started while sequencer busy");
  a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && step_r == '0)
    else $error("sequencer did not enter first step");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= LAST_STEP)
    else $error("step counter out of program range");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n) finish |=> !busy_r)
    else $error("sequencer still busy after finish");
`endif

endmodule

[sv/scfc_dp.sv]
`timescale 1ns / 1ps

module scfc_dp import scfc_pkg::*; (
  input  logic                    clk,
  input  logic                    start,
  input  uop_t                    uop,
  input  logic signed [SMP_W-1:0] cv,
  input  logic signed [SMP_W-1:0] a1,
  input  logic signed [SMP_W-1:0] b1,
  input  logic signed [SMP_W-1:0] a2,
  input  logic signed [SMP_W-1:0] b2,
  input  logic signed [SMP_W-1:0] man_pos,
  input  logic signed [SMP_W-1:0] cv_trim,
  input  logic [1:0]              fade_mode,
  input  logic [CLIP_W-1:0]       clip_limit,
  output logic signed [SMP_W-1:0] left_res,
  output logic signed [SMP_W-1:0] right_res,
  output logic signed [SMP_W-1:0] cur_pos
);

  logic signed [SMP_W-1:0]   cv_r, a1_r, b1_r, a2_r, b2_r, man_r;
  logic signed [SMP_W-1:0]   pos_r, pos_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, rnd;
  logic signed [SMP_W-1:0]   left_r, left_nxt;
  logic signed [OP_W-1:0]    op_a, op_b, u;
  logic signed [SMP_W:0]     wa, wb;
  logic [CLIP_W-1:0]         mag, f, m2, mag_new;
  logic signed [CVSUM_W-1:0] q, cv_sum;
  logic                      is_log;
  logic signed [SMP_W-1:0]   acc_sat;

  // Saturate the rescaled mix to +/- clip limit
  function automatic logic signed [SMP_W-1:0] sat_out(input logic signed [ACC_W-1:0] a,
                                                      input logic [CLIP_W-1:0] lim);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] l;
    logic signed [ACC_W-1:0] r;
    v = a >>> MIX_SHIFT;
    l = signed'(ACC_W'(lim));
    if (v > l)       r = l;
    else if (v < -l) r = -l;
    else             r = v;
    return SMP_W'(r);
  endfunction

  // Derived operands
  always_comb begin
    wb     = (SMP_W+1)'(pos_r) + (SMP_W+1)'(ONE_Q14);
    wa     = (SMP_W+1)'(2 * ONE_Q14) - wb;
    mag    = pos_r[SMP_W-1] ? CLIP_W'(-pos_r) : CLIP_W'(pos_r);
    is_log = (fade_mode == FADE_LOG);
    f      = is_log ? mag : CLIP_W'(ONE_Q14) - mag;
    u      = OP_W'(acc_r >>> CV_SHIFT) + OP_W'(CV_BIAS);
  end

  // Shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (uop.mul)
      MUL_CV_TRIM: begin op_a = OP_W'(cv_r);  op_b = OP_W'(cv_trim);        end
      MUL_RECIP:   begin op_a = u;            op_b = OP_W'(RECIP5);         end
      MUL_CURVE:   begin op_a = OP_W'(f);     op_b = OP_W'(f);              end
      MUL_WA_A1:   begin op_a = OP_W'(wa);    op_b = OP_W'(a1_r);           end
      MUL_WB_B1:   begin op_a = OP_W'(wb);    op_b = OP_W'(b1_r);           end
      MUL_WA_A2:   begin op_a = OP_W'(wa);    op_b = OP_W'(a2_r);           end
      MUL_WB_B2:   begin op_a = OP_W'(wb);    op_b = OP_W'(b2_r);           end
      default:     begin op_a = '0;           op_b = '0;                    end
    endcase
    prod_nxt = (uop.mul == MUL_NONE) ? prod_r : op_a * op_b;
  end

  // Accumulator with rounding constant
  always_comb begin
    case (uop.rnd)
      RND_CV:  rnd = ACC_W'(CV_RND);
      RND_MIX: rnd = ACC_W'(MIX_RND);
      default: rnd = '0;
    endcase
    case (uop.acc)
      ACC_LOAD: acc_nxt = ACC_W'(prod_r) + rnd;
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  // Position update: CV offset with clamp, or curve shaping
  always_comb begin
    q       = CVSUM_W'(prod_r >>> RECIP_SHIFT);
    cv_sum  = CVSUM_W'(man_r) + q - CVSUM_W'(Q_BIAS);
    m2      = CLIP_W'((prod_r + PROD_W'(CURVE_RND)) >>> CURVE_SHIFT);
    mag_new = is_log ? m2 : CLIP_W'(ONE_Q14) - m2;
    case (uop.pos)
      POS_CV: begin
        if (cv_sum > CVSUM_W'(POS_ONE))      pos_nxt = POS_ONE;
        else if (cv_sum < CVSUM_W'(NEG_ONE)) pos_nxt = NEG_ONE;
        else                                 pos_nxt = SMP_W'(cv_sum);
      end
      POS_CURVE: pos_nxt = pos_r[SMP_W-1] ? -SMP_W'(mag_new) : SMP_W'(mag_new);
      default:   pos_nxt = pos_r;
    endcase
  end

  assign acc_sat  = sat_out(acc_r, clip_limit);
  assign left_nxt = uop.left_wr ? acc_sat : left_r;

  // Frame capture at start, otherwise microcode-driven updates
  always_ff @(posedge clk) begin
    if (start) begin
      cv_r  <= cv;
      a1_r  <= a1;
      b1_r  <= b1;
      a2_r  <= a2;
      b2_r  <= b2;
      man_r <= man_pos;
      pos_r <= man_pos;
    end else begin
      pos_r <= pos_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    left_r <= left_nxt;
  end

  assign left_res  = left_r;
  assign right_res = acc_sat;
  assign cur_pos   = man_r;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import scfc_pkg::*;

  localparam int     TOTAL_FRAMES = 650;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     TAIL_CYCLES  = 40;
  localparam int     MAX_PRINTS   = 40;
  // CV scaling divisor: trim/5 V at 2048 LSB per volt
  localparam longint CV_DIV       = 10240;

  typedef struct packed {
    logic signed [SMP_W-1:0] cv;
    logic                    btn;
    logic signed [SMP_W-1:0] a1;
    logic signed [SMP_W-1:0] b1;
    logic signed [SMP_W-1:0] a2;
    logic signed [SMP_W-1:0] b2;
    logic                    a2p;
    logic                    b2p;
  } frame_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic signed [SMP_W-1:0] posn;
  } mix_t;

  typedef enum logic { ROW_FRAME, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [2:0] idx;
    logic [15:0] data;
    frame_t     f;
    bit         typed;
    mix_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  scfc_in_if  in_ch ();
  scfc_out_if out_ch ();
  scfc_cfg_if cfg_ch ();

  stereo_crossfader_with_curve_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's registers and state, values after reset
  logic signed [15:0] m_knob    = 16'sd0;
  logic signed [15:0] m_trim    = 16'sd0;
  logic [1:0]         m_fade    = FADE_LINEAR;
  logic               m_cv_conn = 1'b0;
  logic               m_trig    = 1'b0;
  logic signed [15:0] m_trig_lo = 16'sd205;
  logic signed [15:0] m_trig_hi = 16'sd2048;
  logic [14:0]        m_clip    = 15'd24576;
  ovr_t               m_ovr     = OVR_NONE;
  logic               m_schmitt = 1'b0;

  mix_t mix_due [$];
  row_t dir_rows [$];

  int   frames_sent   = 0;
  int   mixes_checked = 0;
  int   mismatches    = 0;
  int   settings_seen = 0;
  logic hold_off      = 1'b0;
  logic sink_calm     = 1'b0;
  bit   src_calm      = 1'b0;
  logic btn_level     = 1'b0;
  int   stall_left    = 0;

  logic [2:0] reg_order [8] = '{REG_KNOB, REG_TRIM, REG_FADE, REG_CV_CONN,
                                REG_TRIG, REG_TRIG_LO, REG_TRIG_HI, REG_CLIP};

  // ---------------------------------------------------------------
  // Crossfade predictor
  // ---------------------------------------------------------------
  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clip_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint manual_pos();
    longint k;
    k = m_knob;
    case (m_ovr)
      OVR_NEG: return -ONE_Q14;
      OVR_POS: return ONE_Q14;
      default: return clip_to(k, -ONE_Q14, ONE_Q14);
    endcase
  endfunction

  // Hysteresis comparator; true only on the set crossing
  function automatic bit schmitt_fire(longint v, longint lo, longint hi);
    if (m_schmitt) begin
      if (v <= lo) m_schmitt = 1'b0;
      return 1'b0;
    end
    if (v >= hi) begin
      m_schmitt = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void flip_position();
    m_ovr = (manual_pos() >= 0) ? OVR_NEG : OVR_POS;
  endfunction

  function automatic longint mix_pair(longint wa, longint wb, longint a, longint b);
    longint lim;
    lim = m_clip;
    return clip_to(floor_div(wa * a + wb * b + MIX_RND, 2 * ONE_Q14), -lim, lim);
  endfunction

  function automatic mix_t crossfade_predict(frame_t f);
    longint cv, btn, trim, lo, hi, a1, b1, a2, b2, pos, mag, rest, wa, wb;
    mix_t   r;
    cv   = f.cv;
    btn  = f.btn;
    trim = m_trim;
    lo   = m_trig_lo;
    hi   = m_trig_hi;
    a1   = f.a1;
    b1   = f.b1;
    a2   = f.a2;
    b2   = f.b2;
    // absent right inputs fall back to the crossed left ones
    if (!f.a2p) a2 = b1;
    if (!f.b2p) b2 = a1;

    if (!m_cv_conn) begin
      if (schmitt_fire(btn, 0, 1)) flip_position();
      pos = manual_pos();
    end else if (!m_trig) begin
      pos = manual_pos() + floor_div(cv * trim + CV_RND, CV_DIV);
      pos = clip_to(pos, -ONE_Q14, ONE_Q14);
    end else begin
      if (schmitt_fire(cv, lo, hi)) flip_position();
      pos = manual_pos();
    end

    // fade curve on the magnitude, sign restored after
    mag = (pos < 0) ? -pos : pos;
    case (m_fade)
      FADE_LOG: begin
        mag = floor_div(mag * mag + CURVE_RND, ONE_Q14);
        pos = (pos < 0) ? -mag : mag;
      end
      FADE_EXP: begin
        rest = ONE_Q14 - mag;
        mag  = ONE_Q14 - floor_div(rest * rest + CURVE_RND, ONE_Q14);
        pos  = (pos < 0) ? -mag : mag;
      end
      default: ;
    endcase

    wb = pos + ONE_Q14;
    wa = 2 * ONE_Q14 - wb;
    r.left  = 16'(mix_pair(wa, wb, a1, b1));
    r.right = 16'(mix_pair(wa, wb, a2, b2));
    r.posn  = 16'(manual_pos());
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic void add_frame(int cv, int btn, int a1, int b1, int a2, int b2,
                                    int a2p, int b2p, bit typed = 1'b0,
                                    int l = 0, int r = 0, int p = 0);
    row_t row;
    row.kind  = ROW_FRAME;
    row.idx   = REG_KNOB;
    row.data  = '0;
    row.f     = '{cv: 16'(cv), btn: btn[0], a1: 16'(a1), b1: 16'(b1),
                  a2: 16'(a2), b2: 16'(b2), a2p: a2p[0], b2p: b2p[0]};
    row.typed = typed;
    row.want  = '{left: 16'(l), right: 16'(r), posn: 16'(p)};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [2:0] idx, int data);
    row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.data  = 16'(data);
    row.f     = '0;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  task automatic flag_error(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("ERROR @%0t %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic await_drain();
    while (mix_due.size() != 0) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes need no lowering in between
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_KNOB: begin
        m_knob = val;
        m_ovr  = OVR_NONE;
      end
      REG_TRIM:    m_trim    = val;
      REG_FADE:    m_fade    = val[1:0];
      REG_CV_CONN: m_cv_conn = val[0];
      REG_TRIG:    m_trig    = val[0];
      REG_TRIG_LO: m_trig_lo = val;
      REG_TRIG_HI: m_trig_hi = val;
      REG_CLIP:    m_clip    = val[14:0];
      default: ;
    endcase
  endtask

  // One input transaction; the expectation is fixed at the accepting edge
  task automatic send_frame(frame_t f, bit typed, mix_t want);
    in_ch.valid           <= 1'b1;
    in_ch.control_voltage <= f.cv;
    in_ch.toggle_button   <= f.btn;
    in_ch.sample_a1       <= f.a1;
    in_ch.sample_b1       <= f.b1;
    in_ch.sample_a2       <= f.a2;
    in_ch.sample_b2       <= f.b2;
    in_ch.a2_present      <= f.a2p;
    in_ch.b2_present      <= f.b2p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    frames_sent++;
    if (typed) begin
      void'(crossfade_predict(f));
      mix_due.push_back(want);
    end else begin
      mix_due.push_back(crossfade_predict(f));
    end
  endtask

  task automatic frame_gap(bit force_low);
    int gap;
    gap = hold_off ? 0 : pick_gap(src_calm);
    if (gap > 0 || force_low) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------
  // Result side: random backpressure and checking
  // ---------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mix_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mix_due.size() == 0) begin
        flag_error("result with nothing pending, left_out", out_ch.left_out, 0);
      end else begin
        want = mix_due.pop_front();
        mixes_checked++;
        if (out_ch.left_out !== want.left)
          flag_error("left_out", out_ch.left_out, want.left);
        if (out_ch.right_out !== want.right)
          flag_error("right_out", out_ch.right_out, want.right);
        if (out_ch.current_position !== want.posn)
          flag_error("current_position", out_ch.current_position, want.posn);
      end
    end
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap(sink_calm);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin : receiver_holdoff
    wait (frames_sent >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d results still pending", mix_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  initial begin : stimulus
    frame_t      f;
    mix_t        none;
    longint      near;
    int          pick;
    int          n_frames;
    int          n_directed;
    bit          wrote;
    bit          next_frame;
    bit          next_reg;
    logic [15:0] val;

    none = '0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.control_voltage <= '0;
    in_ch.toggle_button   <= 1'b0;
    in_ch.sample_a1       <= '0;
    in_ch.sample_b1       <= '0;
    in_ch.sample_a2       <= '0;
    in_ch.sample_b2       <= '0;
    in_ch.a2_present      <= 1'b0;
    in_ch.b2_present      <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_KNOB;
    cfg_ch.data           <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: centered linear fade, unpatched CV, clip at 12 V
    add_frame(0, 0, 1000, 3000, 0, 0, 0, 0, 1, 2000, 2000, 0);
    add_frame(32767, 0, 32767, 32767, 32767, 32767, 1, 1, 1, 24576, 24576, 0);
    add_frame(-32768, 0, -32768, -32768, -32768, -32768, 1, 1, 1, -24576, -24576, 0);
    // button edges flip the position, held or released levels do nothing
    add_frame(0, 1, 1234, -5000, -7, 99, 1, 1, 1, 1234, -7, -16384);
    add_frame(0, 1, 1234, -5000, -7, 99, 1, 1, 1, 1234, -7, -16384);
    add_frame(0, 0, 1234, -5000, -7, 99, 1, 1, 1, 1234, -7, -16384);
    add_frame(0, 1, 1234, -5000, -7, 99, 1, 1, 1, -5000, 99, 16384);
    // knob write drops the override; out-of-range knob saturates
    add_reg(REG_KNOB, -32768);
    add_frame(0, 0, 500, 600, -1, -1, 0, 0, 1, 500, 600, -16384);
    add_reg(REG_KNOB, 32767);
    add_reg(REG_CLIP, 0);
    add_frame(100, 0, -32768, 32767, 5, 6, 1, 1, 1, 0, 0, 16384);
    // curves, including the unused code that falls back to linear
    add_reg(REG_CLIP, 32767);
    add_reg(REG_FADE, FADE_LOG);
    add_reg(REG_KNOB, 8192);
    add_frame(0, 0, -20000, 20000, 12345, -12345, 1, 1);
    add_reg(REG_KNOB, -8192);
    add_frame(0, 0, -20000, 20000, 12345, -12345, 1, 0);
    add_reg(REG_FADE, FADE_EXP);
    add_frame(0, 0, 30000, -30000, 777, -777, 0, 1);
    add_reg(REG_FADE, FADE_LINEAR | FADE_EXP);
    add_frame(0, 0, 30000, -30000, 777, -777, 1, 1);
    // CV mode: offset clamps at both ends, negative trim, rounding
    add_reg(REG_FADE, FADE_LINEAR);
    add_reg(REG_CV_CONN, 1);
    add_reg(REG_TRIM, 16384);
    add_reg(REG_KNOB, 0);
    add_frame(32767, 1, 10000, -10000, 4000, -4000, 1, 1);
    add_frame(-32768, 0, 10000, -10000, 4000, -4000, 1, 1);
    add_reg(REG_TRIM, -16384);
    add_frame(1000, 1, 10000, -10000, 4000, -4000, 1, 1);
    add_frame(-3, 0, 10000, -10000, 4000, -4000, 1, 1);
    // trigger mode: fire, hold, release, fire again
    add_reg(REG_TRIG, 1);
    add_reg(REG_TRIG_LO, -100);
    add_reg(REG_TRIG_HI, 3000);
    add_frame(3000, 0, 8000, -8000, 100, 200, 1, 1);
    add_frame(0, 1, 8000, -8000, 100, 200, 1, 1);
    add_frame(-100, 0, 8000, -8000, 100, 200, 1, 1);
    add_frame(32767, 0, 8000, -8000, 100, 200, 1, 1);
    // thresholds given in the wrong order still apply as written
    add_reg(REG_TRIG_LO, 4000);
    add_reg(REG_TRIG_HI, -4000);
    add_frame(0, 0, 8000, -8000, 100, 200, 1, 1);
    add_frame(-4000, 0, 8000, -8000, 100, 200, 1, 1);
    add_frame(-32768, 0, 8000, -8000, 100, 200, 1, 1);
    add_reg(REG_KNOB, 0);
    add_frame(0, 0, 8000, -8000, 100, 200, 1, 1);

    for (int i = 0; i < dir_rows.size(); i++) begin
      next_frame = (i + 1 < dir_rows.size()) && (dir_rows[i + 1].kind == ROW_FRAME);
      next_reg   = (i + 1 < dir_rows.size()) && (dir_rows[i + 1].kind == ROW_REG);
      if (dir_rows[i].kind == ROW_REG) begin
        await_drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        if (!next_reg) cfg_ch.valid <= 1'b0;
      end else begin
        send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
        frame_gap(!next_frame);
      end
    end
    n_directed = frames_sent;

    // Random phases: new register settings, then a burst of frames
    while (frames_sent < TOTAL_FRAMES) begin
      await_drain();
      wrote = 1'b0;
      foreach (reg_order[k]) begin
        if ($urandom_range(0, 2) == 0) begin
          pick = $urandom_range(0, 7);
          val  = 16'($urandom);
          case (reg_order[k])
            REG_KNOB, REG_TRIM: begin
              if (pick == 0) val = 16'h8000;
              else if (pick == 1) val = 16'h7FFF;
              else if (pick == 2) val = 16'hC000;
              else if (pick == 3) val = 16'h4000;
              else if (pick == 4) val = 16'h0000;
            end
            REG_TRIG_LO, REG_TRIG_HI: begin
              if (pick == 0) val = 16'h8000;
              else if (pick == 1) val = 16'h7FFF;
              else val = 16'(int'($urandom_range(0, 8192)) - 4096);
            end
            REG_CLIP: begin
              if (pick == 0) val = 16'h0000;
              else if (pick == 1) val = 16'h7FFF;
            end
            default: ;
          endcase
          write_reg(reg_order[k], val);
          wrote = 1'b1;
        end
      end
      if (wrote) cfg_ch.valid <= 1'b0;
      settings_seen++;
      src_calm  = ($urandom_range(0, 4) == 0);
      sink_calm <= ($urandom_range(0, 4) == 0);

      n_frames = $urandom_range(15, 50);
      for (int j = 0; j < n_frames; j++) begin
        // CV often hovers around the thresholds so the trigger keeps firing
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          near = ($urandom_range(0, 1) != 0) ? m_trig_hi : m_trig_lo;
          near = near + int'($urandom_range(0, 16)) - 8;
          if (near > 32767) near = 32767;
          if (near < -32768) near = -32768;
          f.cv = 16'(near);
        end else if (pick < 6) begin
          f.cv = (pick == 4) ? 16'sh7FFF : 16'sh8000;
        end else begin
          f.cv = 16'($urandom);
        end
        if ($urandom_range(0, 2) == 0) btn_level = ~btn_level;
        f.btn = btn_level;
        f.a1  = pick_sample();
        f.b1  = pick_sample();
        f.a2  = pick_sample();
        f.b2  = pick_sample();
        f.a2p = 1'($urandom_range(0, 1));
        f.b2p = 1'($urandom_range(0, 1));
        send_frame(f, 1'b0, none);
        frame_gap(j == n_frames - 1);
      end
    end

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d frames (%0d directed) across %0d random register settings",
             frames_sent, n_directed, settings_seen);
    $display("Checked %0d mixed results, %0d field mismatches", mixes_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
sv/scfc_pkg.sv
sv/scfc_in_if.sv
sv/scfc_out_if.sv
sv/scfc_cfg_if.sv
sv/scfc_seq.sv
sv/scfc_dp.sv
sv/stereo_crossfader_with_curve_top.sv
bench/testbench.sv
